// ===== hdl/cfpr_pkg.sv =====
// Package for the framed packet receiver: constants, result type, CRC-32 byte update.
`default_nettype none
package cfpr_pkg;

  localparam int unsigned MAX_PAYLOAD  = 4096;
  localparam int unsigned HEADER_BYTES = 20;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // output queue, power of two
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned PTR_W     = $clog2(OUT_DEPTH);
  localparam int unsigned CNT_W     = $clog2(OUT_DEPTH + 1);

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_CLOSED     = 3'd1;
  localparam logic [2:0] ST_BAD_HEADER = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd3;
  localparam logic [2:0] ST_CRC        = 3'd4;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [1:0] CFG_MAGIC    = 2'd0;
  localparam logic [1:0] CFG_VERSION  = 2'd1;
  localparam logic [1:0] CFG_CAPACITY = 2'd2;

  localparam logic [15:0] MAGIC_RST    = 16'd0;
  localparam logic [7:0]  VERSION_RST  = 8'd1;
  localparam logic [15:0] CAPACITY_RST = 16'd4096;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload;
    logic [2:0]  status;
    logic [7:0]  frame_type;
    logic [31:0] sequence_number;
    logic [31:0] sender_time;
    logic [31:0] length_field;
    logic [31:0] header_crc;
    logic [31:0] computed_crc;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic result_t make_end(input logic [2:0] st, input logic [7:0] typ,
                                       input logic [31:0] seq, input logic [31:0] tim,
                                       input logic [31:0] len, input logic [31:0] hcrc,
                                       input logic [31:0] comp);
    result_t r;
    r.kind            = KIND_END;
    r.payload         = 8'd0;
    r.status          = st;
    r.frame_type      = typ;
    r.sequence_number = seq;
    r.sender_time     = tim;
    r.length_field    = len;
    r.header_crc      = hcrc;
    r.computed_crc    = comp;
    return r;
  endfunction

  function automatic result_t make_byte(input logic [7:0] b);
    result_t r;
    r         = '0;
    r.kind    = KIND_BYTE;
    r.payload = b;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/crc_framed_packet_receiver_core.sv =====
// Top level: header parser, payload CRC-32 check and output queue of the frame receiver.
// Results are written into the output queue when their byte beat is accepted.
// Throughput: one byte beat per cycle while in_stall is low; the last payload byte
//   yields two results, which leave the 4-entry output queue one at a time. in_stall
//   is high while the queue has fewer than two free entries.
// Reset: parser back to header, queue emptied, registers to magic 0, version 1,
//   capacity 4096. Ready in the cycle after reset.
`default_nettype none
module crc_framed_packet_receiver_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        link_closed,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             result_kind,
  output logic [7:0]       payload_byte,
  output logic [2:0]       status,
  output logic [7:0]       frame_type,
  output logic [31:0]      sequence_number,
  output logic [31:0]      sender_time,
  output logic [31:0]      length_field,
  output logic [31:0]      header_crc,
  output logic [31:0]      computed_crc,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import cfpr_pkg::*;

  typedef enum logic {PH_HEADER, PH_PAYLOAD} phase_t;

  phase_t      phase, phase_next;
  logic [15:0] byte_position, byte_position_next;
  logic [15:0] magic_seen, magic_seen_next;
  logic [7:0]  version_seen, version_seen_next;
  logic [7:0]  type_seen, type_seen_next;
  logic [31:0] sequence_seen, sequence_seen_next;
  logic [31:0] time_seen, time_seen_next;
  logic [31:0] length_seen, length_seen_next;
  logic [31:0] crc_seen, crc_seen_next;
  logic [31:0] running_crc, running_crc_next;

  logic [15:0] expected_magic;
  logic [7:0]  expected_version;
  logic [15:0] capacity_limit;

  result_t            queue [OUT_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  result_t            res0, res1;
  logic [1:0]         n_push;
  logic               in_acc, out_acc;
  logic               push_end;

  assign in_stall  = count > CNT_W'(OUT_DEPTH - 2);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = count != '0;
  assign out_acc   = out_valid && !out_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    logic [15:0] pos_inc;
    logic [31:0] crc_new;
    logic [31:0] crc_hdr;
    phase_next         = phase;
    byte_position_next = byte_position;
    magic_seen_next    = magic_seen;
    version_seen_next  = version_seen;
    type_seen_next     = type_seen;
    sequence_seen_next = sequence_seen;
    time_seen_next     = time_seen;
    length_seen_next   = length_seen;
    crc_seen_next      = crc_seen;
    running_crc_next   = running_crc;
    res0     = '0;
    res1     = '0;
    n_push   = 2'd0;
    push_end = 1'b0;
    pos_inc  = byte_position + 16'd1;
    crc_new  = crc_byte(running_crc, data_byte);
    crc_hdr  = {crc_seen[23:0], data_byte};
    if (in_acc) begin
      if (link_closed) begin
        res0     = make_end(ST_CLOSED, type_seen, sequence_seen, time_seen, length_seen,
                            crc_seen, 32'd0);
        n_push   = 2'd1;
        push_end = 1'b1;
      end else begin
        case (phase)
          PH_PAYLOAD: begin
            res0               = make_byte(data_byte);
            n_push             = 2'd1;
            running_crc_next   = crc_new;
            byte_position_next = pos_inc;
            if ({16'd0, pos_inc} >= length_seen) begin
              res1     = make_end((~crc_new == crc_seen) ? ST_OK : ST_CRC, type_seen,
                                  sequence_seen, time_seen, length_seen, crc_seen, ~crc_new);
              n_push   = 2'd2;
              push_end = 1'b1;
            end
          end
          default: begin
            if (byte_position < 16'd2) begin
              magic_seen_next = {magic_seen[7:0], data_byte};
            end else if (byte_position == 16'd2) begin
              version_seen_next = data_byte;
            end else if (byte_position == 16'd3) begin
              type_seen_next = data_byte;
            end else if (byte_position < 16'd8) begin
              sequence_seen_next = {sequence_seen[23:0], data_byte};
            end else if (byte_position < 16'd12) begin
              time_seen_next = {time_seen[23:0], data_byte};
            end else if (byte_position < 16'd16) begin
              length_seen_next = {length_seen[23:0], data_byte};
            end else begin
              crc_seen_next = crc_hdr;
            end
            byte_position_next = pos_inc;
            if (byte_position == 16'(HEADER_BYTES - 1)) begin
              if (magic_seen != expected_magic || version_seen != expected_version) begin
                res0     = make_end(ST_BAD_HEADER, type_seen, sequence_seen, time_seen,
                                    length_seen, crc_hdr, 32'd0);
                n_push   = 2'd1;
                push_end = 1'b1;
              end else if (length_seen > 32'(MAX_PAYLOAD) ||
                           length_seen > {16'd0, capacity_limit}) begin
                res0     = make_end(ST_TOO_LARGE, type_seen, sequence_seen, time_seen,
                                    length_seen, crc_hdr, 32'd0);
                n_push   = 2'd1;
                push_end = 1'b1;
              end else if (length_seen == 32'd0) begin
                res0     = make_end((~running_crc == crc_hdr) ? ST_OK : ST_CRC, type_seen,
                                    sequence_seen, time_seen, length_seen, crc_hdr,
                                    ~running_crc);
                n_push   = 2'd1;
                push_end = 1'b1;
              end else begin
                phase_next         = PH_PAYLOAD;
                byte_position_next = 16'd0;
                running_crc_next   = CRC_INIT;
              end
            end
          end
        endcase
      end
      if (push_end) begin
        phase_next         = PH_HEADER;
        byte_position_next = 16'd0;
        magic_seen_next    = 16'd0;
        version_seen_next  = 8'd0;
        type_seen_next     = 8'd0;
        sequence_seen_next = 32'd0;
        time_seen_next     = 32'd0;
        length_seen_next   = 32'd0;
        crc_seen_next      = 32'd0;
        running_crc_next   = CRC_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      byte_position    <= 16'd0;
      magic_seen       <= 16'd0;
      version_seen     <= 8'd0;
      type_seen        <= 8'd0;
      sequence_seen    <= 32'd0;
      time_seen        <= 32'd0;
      length_seen      <= 32'd0;
      crc_seen         <= 32'd0;
      running_crc      <= CRC_INIT;
      expected_magic   <= MAGIC_RST;
      expected_version <= VERSION_RST;
      capacity_limit   <= CAPACITY_RST;
    end else begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      magic_seen    <= magic_seen_next;
      version_seen  <= version_seen_next;
      type_seen     <= type_seen_next;
      sequence_seen <= sequence_seen_next;
      time_seen     <= time_seen_next;
      length_seen   <= length_seen_next;
      crc_seen      <= crc_seen_next;
      running_crc   <= running_crc_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAGIC:    expected_magic   <= cfg_data;
          CFG_VERSION:  expected_version <= cfg_data[7:0];
          CFG_CAPACITY: capacity_limit   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // output queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      if (out_acc) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(n_push) - CNT_W'(out_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (n_push == 2'd2) begin
      queue[wr_ptr + PTR_W'(1)] <= res1;
    end
  end

  assign result_kind     = queue[rd_ptr].kind;
  assign payload_byte    = queue[rd_ptr].payload;
  assign status          = queue[rd_ptr].status;
  assign frame_type      = queue[rd_ptr].frame_type;
  assign sequence_number = queue[rd_ptr].sequence_number;
  assign sender_time     = queue[rd_ptr].sender_time;
  assign length_field    = queue[rd_ptr].length_field;
  assign header_crc      = queue[rd_ptr].header_crc;
  assign computed_crc    = queue[rd_ptr].computed_crc;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(OUT_DEPTH))
    else $error("output queue overfilled");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (!in_acc && !out_acc) |=> $stable(count))
    else $error("queue count moved without a beat");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    push_end |=> (phase == PH_HEADER && byte_position == 16'd0 && running_crc == CRC_INIT))
    else $error("parser did not restart after frame end");

  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> (length_seen != 32'd0 && length_seen <= 32'(MAX_PAYLOAD) &&
                             {16'd0, byte_position} < length_seen))
    else $error("payload position outside announced length");

  a_byte_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == KIND_BYTE) |-> (status == ST_OK && computed_crc == 32'd0))
    else $error("payload beat carries end fields");

endmodule
`default_nettype wire

// ===== tb/frame_checker.sv =====
// CRC-32 helper package and the result checker for the framed packet receiver.
package frame_crc_pkg;
  import cfpr_pkg::*;

  function automatic logic [31:0] crc32_next(input logic [31:0] crc, input logic [7:0] d);
    logic [31:0] x;
    x = crc ^ {24'h0, d};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction
endpackage

module frame_checker
  import cfpr_pkg::*;
  import frame_crc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        link_closed,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        result_kind,
  input  logic [7:0]  payload_byte,
  input  logic [2:0]  status,
  input  logic [7:0]  frame_type,
  input  logic [31:0] sequence_number,
  input  logic [31:0] sender_time,
  input  logic [31:0] length_field,
  input  logic [31:0] header_crc,
  input  logic [31:0] computed_crc,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {RX_HEADER, RX_PAYLOAD} rx_phase_t;

  rx_phase_t   rx_phase;
  logic [15:0] rx_pos;
  logic [15:0] hdr_magic;
  logic [7:0]  hdr_ver;
  logic [7:0]  hdr_type;
  logic [31:0] hdr_seq;
  logic [31:0] hdr_time;
  logic [31:0] hdr_len;
  logic [31:0] hdr_crc;
  logic [31:0] pay_crc;

  logic [15:0] want_magic;
  logic [7:0]  want_ver;
  logic [15:0] cap_limit;

  result_t due_results[$];

  task automatic clear_frame();
    rx_phase  = RX_HEADER;
    rx_pos    = '0;
    hdr_magic = '0;
    hdr_ver   = '0;
    hdr_type  = '0;
    hdr_seq   = '0;
    hdr_time  = '0;
    hdr_len   = '0;
    hdr_crc   = '0;
    pay_crc   = CRC_INIT;
  endtask

  task automatic push_end(input logic [2:0] st, input logic [31:0] comp);
    result_t r;
    r.kind            = KIND_END;
    r.payload         = 8'd0;
    r.status          = st;
    r.frame_type      = hdr_type;
    r.sequence_number = hdr_seq;
    r.sender_time     = hdr_time;
    r.length_field    = hdr_len;
    r.header_crc      = hdr_crc;
    r.computed_crc    = comp;
    due_results.push_back(r);
    clear_frame();
  endtask

  task automatic push_payload(input logic [7:0] b);
    result_t r;
    r         = '0;
    r.kind    = KIND_BYTE;
    r.payload = b;
    due_results.push_back(r);
  endtask

  task automatic parse_beat(input logic [7:0] b, input logic closed);
    logic [31:0] fin;
    if (closed) begin
      push_end(ST_CLOSED, 32'd0);
    end else if (rx_phase == RX_PAYLOAD) begin
      push_payload(b);
      pay_crc = crc32_next(pay_crc, b);
      rx_pos  = rx_pos + 16'd1;
      if ({16'd0, rx_pos} >= hdr_len) begin
        fin = ~pay_crc;
        push_end((fin == hdr_crc) ? ST_OK : ST_CRC, fin);
      end
    end else begin
      if (rx_pos < 2) hdr_magic = {hdr_magic[7:0], b};
      else if (rx_pos == 2) hdr_ver = b;
      else if (rx_pos == 3) hdr_type = b;
      else if (rx_pos < 8) hdr_seq = {hdr_seq[23:0], b};
      else if (rx_pos < 12) hdr_time = {hdr_time[23:0], b};
      else if (rx_pos < 16) hdr_len = {hdr_len[23:0], b};
      else hdr_crc = {hdr_crc[23:0], b};

      if ({16'd0, rx_pos} + 32'd1 < HEADER_BYTES) begin
        rx_pos = rx_pos + 16'd1;
      end else if (hdr_magic != want_magic || hdr_ver != want_ver) begin
        push_end(ST_BAD_HEADER, 32'd0);
      end else if (hdr_len > MAX_PAYLOAD || hdr_len > {16'd0, cap_limit}) begin
        push_end(ST_TOO_LARGE, 32'd0);
      end else if (hdr_len == 32'd0) begin
        fin = ~pay_crc;
        push_end((fin == hdr_crc) ? ST_OK : ST_CRC, fin);
      end else begin
        rx_phase = RX_PAYLOAD;
        rx_pos   = '0;
        pay_crc  = CRC_INIT;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] w, input logic [31:0] g);
    if (w !== g) begin
      fail_count++;
      $error("%s expected %0h actual %0h", name, w, g);
    end
  endtask

  task automatic check_result();
    result_t w;
    if (due_results.size() == 0) begin
      fail_count++;
      $error("unexpected result: kind %0d payload %0h status %0d", result_kind, payload_byte,
             status);
    end else begin
      w = due_results.pop_front();
      check_field("result_kind", w.kind, result_kind);
      check_field("payload_byte", w.payload, payload_byte);
      check_field("status", w.status, status);
      check_field("frame_type", w.frame_type, frame_type);
      check_field("sequence_number", w.sequence_number, sequence_number);
      check_field("sender_time", w.sender_time, sender_time);
      check_field("length_field", w.length_field, length_field);
      check_field("header_crc", w.header_crc, header_crc);
      check_field("computed_crc", w.computed_crc, computed_crc);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      due_results.delete();
      clear_frame();
      want_magic = MAGIC_RST;
      want_ver   = VERSION_RST;
      cap_limit  = CAPACITY_RST;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) parse_beat(data_byte, link_closed);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAGIC:    want_magic = cfg_data;
          CFG_VERSION:  want_ver = cfg_data[7:0];
          CFG_CAPACITY: cap_limit = cfg_data;
          default: ;
        endcase
      end
    end
    pending = due_results.size();
  end
endmodule

// ===== tb/testbench.sv =====
// Top of the frame receiver testbench: clock, reset, frame stimulus, stalls and verdict.
module testbench;
  import cfpr_pkg::*;
  import frame_crc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BEATS = 180;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        link_closed;
  logic        out_valid;
  logic        out_stall;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  logic [7:0]  frame_type;
  logic [31:0] sequence_number;
  logic [31:0] sender_time;
  logic [31:0] length_field;
  logic [31:0] header_crc;
  logic [31:0] computed_crc;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int fail_count;
  int pending;
  int beats_sent;
  int cycle_count;
  bit gaps_on;
  bit stalls_on;
  bit hold_req;

  logic [15:0] cur_magic;
  logic [7:0]  cur_ver;
  logic [15:0] cur_cap;

  crc_framed_packet_receiver_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .link_closed(link_closed),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .payload_byte(payload_byte), .status(status),
    .frame_type(frame_type), .sequence_number(sequence_number),
    .sender_time(sender_time), .length_field(length_field),
    .header_crc(header_crc), .computed_crc(computed_crc),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  frame_checker frame_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .link_closed(link_closed),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .payload_byte(payload_byte), .status(status),
    .frame_type(frame_type), .sequence_number(sequence_number),
    .sender_time(sender_time), .length_field(length_field),
    .header_crc(header_crc), .computed_crc(computed_crc),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return $urandom_range(20, 60);
    if (r < 70) return $urandom_range(1, 2);
    return $urandom_range(3, 6);
  endfunction

  // receiver side: random short stalls, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        hold_req  = 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat (idle_len()) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic closed);
    int gap;
    gap = (gaps_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    repeat (gap) @(negedge clk);
    data_byte   = b;
    link_closed = closed;
    in_valid    = 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    @(negedge clk);
    in_valid = 1'b0;
    beats_sent++;
  endtask

  // header plus n_pay payload beats; cut_at replaces that beat with a link close and ends the frame
  task automatic send_frame(input logic [15:0] mg, input logic [7:0] ver,
                            input logic [7:0] typ, input logic [31:0] seq,
                            input logic [31:0] tim, input logic [31:0] len,
                            input int n_pay, input bit bad_crc, input int cut_at);
    logic [7:0]   pay[$];
    logic [31:0]  c;
    logic [159:0] hv;
    c = CRC_INIT;
    for (int k = 0; k < n_pay; k++) begin
      pay.push_back(8'($urandom));
      c = crc32_next(c, pay[k]);
    end
    c = ~c;
    if (bad_crc) c = c ^ (32'h1 << $urandom_range(0, 31));
    hv = {mg, ver, typ, seq, tim, len, c};
    for (int k = 0; k < HEADER_BYTES + n_pay; k++) begin
      if (k == cut_at) begin
        send_beat(8'($urandom), 1'b1);
        return;
      end
      send_beat((k < HEADER_BYTES) ? hv[159 - 8 * k -: 8] : pay[k - HEADER_BYTES], 1'b0);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
    case (idx)
      CFG_MAGIC:   cur_magic = val;
      CFG_VERSION: cur_ver = val[7:0];
      default:     cur_cap = val;
    endcase
  endtask

  task automatic set_config(input logic [15:0] mg, input logic [7:0] ver, input logic [15:0] cap);
    wait (pending == 0);
    repeat (8) @(negedge clk);
    write_reg(CFG_MAGIC, mg);
    write_reg(CFG_VERSION, {8'd0, ver});
    write_reg(CFG_CAPACITY, cap);
  endtask

  function automatic int accept_limit();
    return (cur_cap < MAX_PAYLOAD) ? int'(cur_cap) : int'(MAX_PAYLOAD);
  endfunction

  task automatic random_frame();
    int          r;
    int          n;
    int          lim;
    logic [31:0] len;
    logic [31:0] big;
    logic [15:0] mg;
    logic [7:0]  ver;
    r   = $urandom_range(0, 99);
    n   = $urandom_range(0, 99);
    lim = accept_limit();
    if (n < 75 && lim > 16) lim = 16;
    else if (n < 95 && lim > 64) lim = 64;
    else if (lim > 512) lim = 512;
    len = $urandom_range(0, lim);
    mg  = cur_magic;
    ver = cur_ver;
    if (r < 68) begin
      send_frame(mg, ver, 8'($urandom), $urandom, $urandom, len, len,
                 $urandom_range(0, 3) == 0, -1);
    end else if (r < 76) begin
      if ($urandom_range(0, 1)) mg = mg ^ (16'h1 << $urandom_range(0, 15));
      else ver = ver ^ (8'h1 << $urandom_range(0, 7));
      if ($urandom_range(0, 1)) len = $urandom;
      send_frame(mg, ver, 8'($urandom), $urandom, $urandom, len, 0, 1'b0, -1);
    end else if (r < 84) begin
      big = $urandom_range(0, 1) ? accept_limit() + 1 + $urandom_range(0, 300)
                                 : ($urandom | 32'h8000_0000);
      send_frame(mg, ver, 8'($urandom), $urandom, $urandom, big, 0, 1'b0, -1);
    end else if (r < 92) begin
      send_frame(mg, ver, 8'($urandom), $urandom, $urandom, len, len,
                 $urandom_range(0, 3) == 0, $urandom_range(0, HEADER_BYTES - 1 + len));
    end else begin
      repeat ($urandom_range(1, 30)) send_beat(8'($urandom), $urandom_range(0, 15) == 0);
      send_beat(8'($urandom), 1'b1);
    end
  endtask

  initial begin
    int mark;
    rst         = 1'b1;
    in_valid    = 1'b0;
    data_byte   = '0;
    link_closed = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    hold_req    = 1'b0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    beats_sent  = 0;
    cur_magic   = MAGIC_RST;
    cur_ver     = VERSION_RST;
    cur_cap     = CAPACITY_RST;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed frames under reset register values
    send_frame(16'h0000, 8'h01, 8'h00, 32'h0, 32'h0, 32'd0, 0, 1'b0, -1);
    send_frame(16'h0000, 8'h01, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 0, 1'b1, -1);
    send_frame(16'h0000, 8'h01, 8'h01, $urandom, $urandom, 32'd1, 1, 1'b0, -1);
    send_frame(16'h0000, 8'h01, 8'($urandom), $urandom, $urandom, 32'd5, 5, 1'b1, -1);
    send_frame(16'h0001, 8'h01, 8'($urandom), $urandom, $urandom, 32'd4, 0, 1'b0, -1);
    send_frame(16'hFFFF, 8'h01, 8'($urandom), $urandom, $urandom, 32'd0, 0, 1'b0, -1);
    send_frame(16'h0000, 8'h02, 8'($urandom), $urandom, $urandom, 32'hFFFF_FFFF, 0, 1'b0, -1);
    send_frame(16'h0000, 8'h01, 8'($urandom), $urandom, $urandom, MAX_PAYLOAD + 1, 0,
               1'b0, -1);
    send_frame(16'h0000, 8'h01, 8'($urandom), $urandom, $urandom, 32'hFFFF_FFFF, 0, 1'b0, -1);
    send_beat(8'hFF, 1'b1);
    send_frame(16'h0000, 8'h01, 8'($urandom), $urandom, $urandom, 32'd8, 8, 1'b0, 10);
    send_frame(16'h0000, 8'h01, 8'($urandom), $urandom, $urandom, 32'd8, 8, 1'b0, 19);
    send_frame(16'h0000, 8'h01, 8'($urandom), $urandom, $urandom, 32'd8, 8, 1'b0, 24);
    send_frame(16'h0000, 8'h01, 8'($urandom), $urandom, $urandom, 32'd8, 8, 1'b0, 27);
    send_beat(8'h00, 1'b1);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       set_config(16'hFFFF, 8'h00, 16'h0000);
        1:       set_config(16'h0000, 8'hFF, 16'hFFFF);
        2:       set_config(16'($urandom), 8'($urandom), 16'($urandom_range(1, 100)));
        3:       set_config(16'($urandom), 8'($urandom), 16'(MAX_PAYLOAD));
        default: set_config(16'($urandom), 8'($urandom), 16'($urandom));
      endcase
      gaps_on   = ph inside {1, 2, 3};
      stalls_on = ph inside {1, 2, 4};
      mark      = beats_sent;
      send_frame(cur_magic, cur_ver, 8'($urandom), $urandom, $urandom, accept_limit() + 1, 0,
                 1'b0, -1);
      // length right at the capacity limit
      if (accept_limit() <= 128)
        send_frame(cur_magic, cur_ver, 8'($urandom), $urandom, $urandom, accept_limit(),
                   accept_limit(), 1'b0, -1);
      if (ph == 1) begin
        // long receiver hold-off while frames keep coming
        hold_req = 1'b1;
        repeat (3) send_frame(cur_magic, cur_ver, 8'($urandom), $urandom, $urandom, 32'd40, 40,
                              1'b0, -1);
      end
      while (beats_sent < mark + PHASE_BEATS) random_frame();
    end

    wait (pending == 0);
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
